FILE: rtl/core/bprl_pkg.sv
`timescale 1ns / 1ps

package bprl_pkg;

    localparam int IN_BITS  = 80;
    localparam int OUT_BITS = 80;

    typedef struct packed {
        logic [31:0]        name_tag;
        logic               good_flag;
        logic signed [31:0] price;
    } record_t;

    // Input request, last field in the lowest bits.
    typedef struct packed {
        logic [6:0]         pad;
        logic signed [31:0] price;
        logic               good_flag;
        logic [31:0]        name_tag;
        logic [4:0]         position;
        logic [2:0]         operation;
    } cmd_t;

    // Result, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]         removed_count;
        logic               position_valid;
        logic               list_full;
        logic               list_empty;
        logic [4:0]         entry_count;
        logic signed [31:0] entry_price;
        logic               entry_good;
        logic [31:0]        entry_name;
        logic [1:0]         status;
    } result_t;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_PURGE  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SH_NOP,
        SH_INSERT,
        SH_DELETE
    } shift_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } state_t;

    localparam logic [4:0] LIMIT_RESET = 5'd16;

endpackage

FILE: rtl/core/bounded_positional_record_list_top.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY records held in a row of cells that shift
// toward or away from a position. A request is latched when taken and
// executed in S_EXEC; append, insert, delete, clear and read wait there
// until the output register is free and then load their result. A purge
// visits one record per cycle through the single read port of the cell row,
// comparing it and, if it falls below the threshold, shifting the tail down
// in place, and loads its result from S_FINISH. The next request is taken
// as soon as the block is back at rest, even while the last result still
// waits in the output register.
module bounded_positional_record_list_top #(
    parameter int CAPACITY = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // operation[2:0], position[7:3], name_tag[39:8], good_flag[40],
    // price[72:41], zero fill up to bit 79
    input  logic [bprl_pkg::IN_BITS-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // status[1:0], entry_name[33:2], entry_good[34], entry_price[66:35],
    // entry_count[71:67], list_empty[72], list_full[73], position_valid[74],
    // removed_count[79:75]
    output logic [bprl_pkg::OUT_BITS-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [4:0]                    cfg_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready
);
    import bprl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int W  = (CW > 5) ? CW : 5;

    state_t state_reg, state_next;

    cmd_t    cmd_reg;
    cmd_t    s_cmd;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] removed_reg, removed_next;
    logic          valid_reg, valid_next;
    logic [4:0]    limit_reg;
    logic          m_tvalid_reg, m_tvalid_next;
    result_t       out_reg, out_next;

    shift_t        chain_kind;
    logic [IW-1:0] chain_idx;
    record_t       wr_rec;
    record_t       rd_rec;

    logic [W-1:0]  count_w, lim_w, cap_w, lim_eff, pos_w;
    logic          room, pos_ok, out_free, scan_end, below;

    assign s_cmd     = cmd_t'(s_tdata);
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign count_w  = W'(count_reg);
    assign lim_w    = W'(limit_reg);
    assign cap_w    = W'(CAPACITY);
    assign lim_eff  = (lim_w > cap_w) ? cap_w : lim_w;
    assign pos_w    = W'(cmd_reg.position);
    assign room     = count_w < lim_eff;
    assign pos_ok   = pos_w < count_w;
    assign scan_end = scan_reg >= count_reg;
    assign below    = rd_rec.price < cmd_reg.price;

    assign wr_rec.name_tag  = cmd_reg.name_tag;
    assign wr_rec.good_flag = cmd_reg.good_flag;
    assign wr_rec.price     = cmd_reg.price;

    bprl_chain #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_chain (
        .clk    (clk),
        .kind   (chain_kind),
        .idx    (chain_idx),
        .wr_rec (wr_rec),
        .rd_rec (rd_rec)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg.operation == OP_PURGE)
                begin
                    state_next = S_SCAN;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic [1:0]    st;
        logic [CW-1:0] rem;
        record_t       ent;
        logic          load;

        st            = ST_DONE;
        rem           = '0;
        ent           = '0;
        load          = 1'b0;
        chain_kind    = SH_NOP;
        chain_idx     = pos_w[IW-1:0];
        count_next    = count_reg;
        scan_next     = scan_reg;
        removed_next  = removed_reg;
        valid_next    = valid_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_next      = out_reg;

        unique case (state_reg)
            S_EXEC:
            begin
                if (cmd_reg.operation == OP_PURGE)
                begin
                    scan_next    = '0;
                    removed_next = '0;
                    valid_next   = pos_ok;
                end
                else if (out_free)
                begin
                    load = 1'b1;
                    unique case (cmd_reg.operation)
                        OP_APPEND:
                        begin
                            if (!room)
                            begin
                                st = ST_FULL;
                            end
                            else
                            begin
                                chain_kind = SH_INSERT;
                                chain_idx  = count_reg[IW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_INSERT:
                        begin
                            // Fullness is checked before the position.
                            if (!room)
                            begin
                                st = ST_FULL;
                            end
                            else if (pos_w > count_w)
                            begin
                                st = ST_INVALID;
                            end
                            else
                            begin
                                chain_kind = SH_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!pos_ok)
                            begin
                                st = ST_INVALID;
                            end
                            else
                            begin
                                chain_kind = SH_DELETE;
                                count_next = count_reg - 1'b1;
                                rem        = CW'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            rem        = count_reg;
                            count_next = '0;
                        end
                        OP_READ:
                        begin
                            if (!pos_ok)
                            begin
                                st = ST_INVALID;
                            end
                            else
                            begin
                                ent = rd_rec;
                            end
                        end
                        default:
                        begin
                            st = ST_DONE;
                        end
                    endcase
                    valid_next = pos_ok;
                end
            end
            S_SCAN:
            begin
                chain_idx = scan_reg[IW-1:0];
                if (!scan_end)
                begin
                    if (below)
                    begin
                        // Shift the tail down; the same slot is looked at again.
                        chain_kind   = SH_DELETE;
                        count_next   = count_reg - 1'b1;
                        removed_next = removed_reg + 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    rem  = removed_reg;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        if (load)
        begin
            m_tvalid_next           = 1'b1;
            out_next.status         = st;
            out_next.entry_name     = ent.name_tag;
            out_next.entry_good     = ent.good_flag;
            out_next.entry_price    = ent.price;
            out_next.entry_count    = 5'(count_next);
            out_next.list_empty     = (count_next == '0);
            out_next.list_full      = (W'(count_next) >= lim_eff);
            out_next.position_valid = valid_next;
            out_next.removed_count  = 5'(rem);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            removed_reg  <= '0;
            valid_reg    <= 1'b0;
            limit_reg    <= LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            removed_reg  <= removed_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_cmd;
        end
    end

endmodule

FILE: rtl/core/bprl_cell.sv
`timescale 1ns / 1ps

module bprl_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic              clk,
    input  bprl_pkg::shift_t  kind,
    input  logic [IW-1:0]     idx,
    input  bprl_pkg::record_t wr_rec,
    input  bprl_pkg::record_t left_rec,
    input  bprl_pkg::record_t right_rec,
    output bprl_pkg::record_t rec
);
    import bprl_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    record_t rec_reg;
    record_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        case (kind)
            SH_INSERT:
            begin
                if (MY_IDX == idx)
                begin
                    rec_next = wr_rec;
                end
                else if (MY_IDX > idx)
                begin
                    rec_next = left_rec;
                end
            end
            SH_DELETE:
            begin
                if (MY_IDX >= idx)
                begin
                    rec_next = right_rec;
                end
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

FILE: rtl/core/bprl_chain.sv
`timescale 1ns / 1ps

module bprl_chain #(
    parameter int CAPACITY = 16,
    parameter int IW       = 4
) (
    input  logic              clk,
    input  bprl_pkg::shift_t  kind,
    input  logic [IW-1:0]     idx,
    input  bprl_pkg::record_t wr_rec,
    output bprl_pkg::record_t rd_rec
);
    import bprl_pkg::*;

    record_t cells [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            record_t left_rec;
            record_t right_rec;

            if (g == 0)
            begin : g_first
                assign left_rec = wr_rec;
            end
            else
            begin : g_mid_l
                assign left_rec = cells[g-1];
            end

            // The last cell has nothing to its right; what it holds after a
            // delete lies beyond the count and is never read.
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_rec = cells[g];
            end
            else
            begin : g_mid_r
                assign right_rec = cells[g+1];
            end

            bprl_cell #(
                .IDX (g),
                .IW  (IW)
            ) u_cell (
                .clk       (clk),
                .kind      (kind),
                .idx       (idx),
                .wr_rec    (wr_rec),
                .left_rec  (left_rec),
                .right_rec (right_rec),
                .rec       (cells[g])
            );
        end
    endgenerate

    assign rd_rec = cells[idx];

endmodule
